/* rtl/core/direction_to_equirect_uv_core_defines.svh */
// Assertion macros shared by the direction to equirect uv core.
`ifndef DIRECTION_TO_EQUIRECT_UV_CORE_DEFINES_SVH
`define DIRECTION_TO_EQUIRECT_UV_CORE_DEFINES_SVH

// Condition must hold on every clock edge out of reset.
`define D2EU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define D2EU_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define D2EU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/d2eu_pkg.sv */
// Shared constants, types and the arctangent table of the direction to equirect uv core.
package d2eu_pkg;

    // field widths
    localparam int IN_W       = 16;
    localparam int TEX_U_W    = 16;
    localparam int TEX_V_W    = 17;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    // datapath: components scaled by 2^20, two guard bits over CORDIC growth
    localparam int PRESCALE_SHIFT = 20;
    localparam int CORDIC_W       = 40;
    localparam int ANGLE_W        = 32;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int ROTATION_STEPS_DEFAULT = 18;

    // gain multiply split into two partial products
    localparam int GAIN_LO_W   = 20;
    localparam int GAIN_HI_W   = CORDIC_W - GAIN_LO_W;
    localparam int GAIN_K_W    = 24;
    localparam int GAIN_PROD_W = GAIN_HI_W + GAIN_K_W;
    localparam int GAIN_SUM_W  = GAIN_PROD_W + GAIN_LO_W;
    localparam logic [GAIN_K_W-1:0] INV_GAIN_Q24 = 24'd10188014;

    // angle and output constants
    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] U_ROUND   = 32'h0000_8000;
    localparam logic [TEX_V_W-1:0] V_ZERO    = 17'd32768;
    localparam logic [TEX_V_W-1:0] V_MAX     = 17'd65536;
    localparam int V_SUM_W = 50;

    // output buffer status seen by the top level
    typedef struct packed {
        logic [1:0] count;
        logic       has_room;
    } buf_status_t;

    // atan(2^-i) in units of 2^-32 turn, truncated
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANGLE_W-1:0] val;
        unique case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2F9;
            5'd15:   val = 32'h0000_517C;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A2F;
            5'd19:   val = 32'h0000_0517;
            5'd20:   val = 32'h0000_028B;
            5'd21:   val = 32'h0000_0145;
            5'd22:   val = 32'h0000_00A2;
            5'd23:   val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/d2eu_cordic_cell.sv */
// One CORDIC vectoring micro-rotation cell with its pipeline register and sideband.
module d2eu_cordic_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic signed [d2eu_pkg::CORDIC_W-1:0]        in_x,
    input  logic signed [d2eu_pkg::CORDIC_W-1:0]        in_y,
    input  logic        [d2eu_pkg::ANGLE_W-1:0]         in_a,
    input  logic        [SIDE_W-1:0]                    in_side,
    output logic                                        out_valid,
    output logic signed [d2eu_pkg::CORDIC_W-1:0]        out_x,
    output logic signed [d2eu_pkg::CORDIC_W-1:0]        out_y,
    output logic        [d2eu_pkg::ANGLE_W-1:0]         out_a,
    output logic        [SIDE_W-1:0]                    out_side
);

    localparam logic [d2eu_pkg::ANGLE_W-1:0] ATAN_STEP = d2eu_pkg::atan_turn(5'(STEP));

    logic                                  valid_reg;
    logic signed [d2eu_pkg::CORDIC_W-1:0]  x_reg, y_reg, x_next, y_next;
    logic        [d2eu_pkg::ANGLE_W-1:0]   a_reg, a_next;
    logic        [SIDE_W-1:0]              side_reg;
    logic signed [d2eu_pkg::CORDIC_W-1:0]  dx, dy;
    logic                                  y_pos;

    // shift-add rotation toward y = 0; arithmetic shift floors
    always_comb begin
        dx    = in_y >>> STEP;
        dy    = in_x >>> STEP;
        y_pos = !in_y[d2eu_pkg::CORDIC_W-1] && (in_y != '0);
        if (y_pos) begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            a_next = in_a + ATAN_STEP;
        end else begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            a_next = in_a - ATAN_STEP;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            a_reg    <= a_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_a     = a_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/core/d2eu_out_buf.sv */
// Two-entry output buffer that decouples the pipeline enable from the result ready.
module d2eu_out_buf #(
    parameter int W = 34
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [W-1:0]            push_data,
    input  logic                    pop_ready,
    output logic                    out_valid,
    output logic [W-1:0]            out_data,
    output d2eu_pkg::buf_status_t   status
);

    logic [W-1:0] mem_reg [0:1];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && pop_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // room is judged from the registered count only
    assign status.count    = count_reg;
    assign status.has_room = (count_reg != 2'd2);

endmodule

/* rtl/core/direction_to_equirect_uv_core.sv */
// Top level: direction vector to equirectangular u/v through two CORDIC cell chains.
//
//  channel   dir   item contents
//  s_        in    one direction vector (dir_x, dir_y, dir_z)
//  m_        out   one texture coordinate pair (tex_u, tex_v) plus zero_vector flag
//
// One item accepted per cycle, sustained while the output buffer has room.
// The pipeline runs through two cell rows (longitude, then latitude), one micro-rotation
// per cell, with a two-stage gain multiply between them.
// Reset (aresetn low, synchronous) clears all valid flags and the output buffer.
// A stall on m_ freezes the whole pipeline once the two-entry output buffer is full;
// s_tready follows the registered buffer count, not m_tready.
module direction_to_equirect_uv_core #(
    parameter int ROTATION_STEPS = d2eu_pkg::ROTATION_STEPS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: dir_x [15:0], dir_y [31:16], dir_z [47:32]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [d2eu_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: tex_u [15:0], tex_v [32:16], zero fill [39:33]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [d2eu_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: zero_vector [0]
    output logic                                m_tuser
);

`include "direction_to_equirect_uv_core_defines.svh"

    localparam int CW     = d2eu_pkg::CORDIC_W;
    localparam int AW     = d2eu_pkg::ANGLE_W;
    localparam int IW     = d2eu_pkg::IN_W;
    localparam int SH     = d2eu_pkg::PRESCALE_SHIFT;
    localparam int UW     = d2eu_pkg::TEX_U_W;
    localparam int VW     = d2eu_pkg::TEX_V_W;
    localparam int LON_SW = CW + 2;
    localparam int LAT_SW = UW + 1;
    localparam int BUF_W  = UW + VW + 1;
    localparam int VSW    = d2eu_pkg::V_SUM_W;
    localparam logic signed [VSW-1:0] V_BIAS = (VSW'(1) <<< 47) + (VSW'(1) <<< 14);

    logic                 en;
    d2eu_pkg::buf_status_t buf_status;

    // input fields
    logic signed [IW-1:0] dir_x, dir_y, dir_z;
    assign dir_x = s_tdata[IW-1:0];
    assign dir_y = s_tdata[2*IW-1:IW];
    assign dir_z = s_tdata[3*IW-1:2*IW];

    // ---------------- prescale and half-turn stage ----------------
    logic signed [CW-1:0] x_sc, y_sc, z_sc;
    logic signed [CW-1:0] s0_x_next, s0_y_next;
    logic [AW-1:0]        s0_a_next;
    logic                 s0_axis_next, s0_zero_next;

    logic                 s0_valid_reg;
    logic signed [CW-1:0] s0_x_reg, s0_y_reg, s0_z_reg;
    logic [AW-1:0]        s0_a_reg;
    logic                 s0_axis_reg, s0_zero_reg;

    always_comb begin
        x_sc = {{(CW-IW-SH){dir_x[IW-1]}}, dir_x, {SH{1'b0}}};
        y_sc = {{(CW-IW-SH){dir_y[IW-1]}}, dir_y, {SH{1'b0}}};
        z_sc = {{(CW-IW-SH){dir_z[IW-1]}}, dir_z, {SH{1'b0}}};
        if (dir_x[IW-1]) begin
            s0_x_next = -x_sc;
            s0_y_next = -y_sc;
            s0_a_next = d2eu_pkg::HALF_TURN;
        end else begin
            s0_x_next = x_sc;
            s0_y_next = y_sc;
            s0_a_next = '0;
        end
        s0_axis_next = (dir_x == '0) && (dir_y == '0);
        s0_zero_next = s0_axis_next && (dir_z == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_x_reg    <= s0_x_next;
            s0_y_reg    <= s0_y_next;
            s0_z_reg    <= z_sc;
            s0_a_reg    <= s0_a_next;
            s0_axis_reg <= s0_axis_next;
            s0_zero_reg <= s0_zero_next;
        end
    end

    // ---------------- longitude cell row ----------------
    logic                 lon_valid [0:ROTATION_STEPS];
    logic signed [CW-1:0] lon_x     [0:ROTATION_STEPS];
    logic signed [CW-1:0] lon_y     [0:ROTATION_STEPS];
    logic [AW-1:0]        lon_a     [0:ROTATION_STEPS];
    logic [LON_SW-1:0]    lon_side  [0:ROTATION_STEPS];

    assign lon_valid[0] = s0_valid_reg;
    assign lon_x[0]     = s0_x_reg;
    assign lon_y[0]     = s0_y_reg;
    assign lon_a[0]     = s0_a_reg;
    assign lon_side[0]  = {s0_z_reg, s0_axis_reg, s0_zero_reg};

    for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_lon
        d2eu_cordic_cell #(
            .STEP   (i),
            .SIDE_W (LON_SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (lon_valid[i]),
            .in_x      (lon_x[i]),
            .in_y      (lon_y[i]),
            .in_a      (lon_a[i]),
            .in_side   (lon_side[i]),
            .out_valid (lon_valid[i+1]),
            .out_x     (lon_x[i+1]),
            .out_y     (lon_y[i+1]),
            .out_a     (lon_a[i+1]),
            .out_side  (lon_side[i+1])
        );
    end

    // ---------------- gain stage A: u rounding, partial products ----------------
    logic signed [CW-1:0]              lon_x_end, lon_z_end, x_pos;
    logic                              lon_axis_end, lon_zero_end;
    logic [AW:0]                       u_sum;
    logic [UW-1:0]                     ga_u_next;
    logic [d2eu_pkg::GAIN_PROD_W-1:0]  ga_phi_next, ga_plo_next;

    logic                              ga_valid_reg;
    logic [d2eu_pkg::GAIN_PROD_W-1:0]  ga_phi_reg, ga_plo_reg;
    logic [UW-1:0]                     ga_u_reg;
    logic signed [CW-1:0]              ga_z_reg;
    logic                              ga_axis_reg, ga_zero_reg;

    always_comb begin
        lon_x_end    = lon_x[ROTATION_STEPS];
        lon_z_end    = lon_side[ROTATION_STEPS][LON_SW-1:2];
        lon_axis_end = lon_side[ROTATION_STEPS][1];
        lon_zero_end = lon_side[ROTATION_STEPS][0];
        // round half up, a full turn wraps to zero
        u_sum        = {1'b0, lon_a[ROTATION_STEPS]} + {1'b0, d2eu_pkg::U_ROUND};
        ga_u_next    = lon_axis_end ? '0 : u_sum[AW-1:AW-UW];
        x_pos        = lon_x_end[CW-1] ? '0 : lon_x_end;
        ga_phi_next  = d2eu_pkg::GAIN_PROD_W'(x_pos[CW-1:d2eu_pkg::GAIN_LO_W])
                     * d2eu_pkg::GAIN_PROD_W'(d2eu_pkg::INV_GAIN_Q24);
        ga_plo_next  = d2eu_pkg::GAIN_PROD_W'(x_pos[d2eu_pkg::GAIN_LO_W-1:0])
                     * d2eu_pkg::GAIN_PROD_W'(d2eu_pkg::INV_GAIN_Q24);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ga_valid_reg <= 1'b0;
        end else if (en) begin
            ga_valid_reg <= lon_valid[ROTATION_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ga_phi_reg  <= ga_phi_next;
            ga_plo_reg  <= ga_plo_next;
            ga_u_reg    <= ga_u_next;
            ga_z_reg    <= lon_z_end;
            ga_axis_reg <= lon_axis_end;
            ga_zero_reg <= lon_zero_end;
        end
    end

    // ---------------- gain stage B: combine and round to r ----------------
    logic [d2eu_pkg::GAIN_SUM_W-1:0] gain_sum;
    logic signed [CW-1:0]            gb_r_next;

    logic                            gb_valid_reg;
    logic signed [CW-1:0]            gb_r_reg, gb_z_reg;
    logic [UW-1:0]                   gb_u_reg;
    logic                            gb_zero_reg;

    always_comb begin
        gain_sum  = {ga_phi_reg, {d2eu_pkg::GAIN_LO_W{1'b0}}}
                  + d2eu_pkg::GAIN_SUM_W'(ga_plo_reg)
                  + (d2eu_pkg::GAIN_SUM_W'(1) << 23);
        gb_r_next = ga_axis_reg ? '0 : gain_sum[d2eu_pkg::GAIN_SUM_W-1:24];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gb_valid_reg <= 1'b0;
        end else if (en) begin
            gb_valid_reg <= ga_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gb_r_reg    <= gb_r_next;
            gb_z_reg    <= ga_z_reg;
            gb_u_reg    <= ga_u_reg;
            gb_zero_reg <= ga_zero_reg;
        end
    end

    // ---------------- latitude cell row ----------------
    logic                 lat_valid [0:ROTATION_STEPS];
    logic signed [CW-1:0] lat_x     [0:ROTATION_STEPS];
    logic signed [CW-1:0] lat_y     [0:ROTATION_STEPS];
    logic [AW-1:0]        lat_a     [0:ROTATION_STEPS];
    logic [LAT_SW-1:0]    lat_side  [0:ROTATION_STEPS];

    assign lat_valid[0] = gb_valid_reg;
    assign lat_x[0]     = gb_r_reg;
    assign lat_y[0]     = gb_z_reg;
    assign lat_a[0]     = '0;
    assign lat_side[0]  = {gb_u_reg, gb_zero_reg};

    for (genvar j = 0; j < ROTATION_STEPS; j++) begin : g_lat
        d2eu_cordic_cell #(
            .STEP   (j),
            .SIDE_W (LAT_SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (lat_valid[j]),
            .in_x      (lat_x[j]),
            .in_y      (lat_y[j]),
            .in_a      (lat_a[j]),
            .in_side   (lat_side[j]),
            .out_valid (lat_valid[j+1]),
            .out_x     (lat_x[j+1]),
            .out_y     (lat_y[j+1]),
            .out_a     (lat_a[j+1]),
            .out_side  (lat_side[j+1])
        );
    end

    // ---------------- v mapping, clamp, zero-vector override ----------------
    logic signed [VSW-1:0] v_sum;
    logic [VSW-16:0]       v_full;
    logic [UW-1:0]         u_out;
    logic [VW-1:0]         v_out;
    logic                  zero_out;
    logic [BUF_W-1:0]      buf_in, buf_out;

    always_comb begin
        v_sum    = V_BIAS - {{(VSW-AW){lat_a[ROTATION_STEPS][AW-1]}}, lat_a[ROTATION_STEPS]};
        v_full   = v_sum[VSW-1:15];
        zero_out = lat_side[ROTATION_STEPS][0];
        u_out    = lat_side[ROTATION_STEPS][LAT_SW-1:1];
        if (v_sum[VSW-1]) begin
            v_out = '0;
        end else if (v_full > (VSW-15)'(d2eu_pkg::V_MAX)) begin
            v_out = d2eu_pkg::V_MAX;
        end else begin
            v_out = v_full[VW-1:0];
        end
        if (zero_out) begin
            u_out = '0;
            v_out = d2eu_pkg::V_ZERO;
        end
        buf_in = {zero_out, v_out, u_out};
    end

    // ---------------- output buffer ----------------
    d2eu_out_buf #(
        .W (BUF_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && lat_valid[ROTATION_STEPS]),
        .push_data (buf_in),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (buf_out),
        .status    (buf_status)
    );

    assign en       = buf_status.has_room;
    assign s_tready = en;
    assign m_tdata  = {{(d2eu_pkg::M_TDATA_W-UW-VW){1'b0}}, buf_out[UW+VW-1:0]};
    assign m_tuser  = buf_out[BUF_W-1];

    // ---------------- assertions ----------------
    `D2EU_ASSERT_ALWAYS(a_buf_count_range, buf_status.count != 2'd3,
        "output buffer count out of range")
    `D2EU_ASSERT_IMPLIES(a_full_blocks_input, buf_status.count == 2'd2, !s_tready,
        "input accepted while output buffer full")
    `D2EU_ASSERT_IMPLIES(a_zero_vector_fixed, m_tvalid && m_tuser,
        (m_tdata[UW-1:0] == '0) && (m_tdata[UW+VW-1:UW] == d2eu_pkg::V_ZERO),
        "zero vector item with wrong coordinates")
    `D2EU_ASSERT_NEXT(a_stall_holds_pipe, !en && lat_valid[ROTATION_STEPS],
        lat_valid[ROTATION_STEPS] && $stable(lat_a[ROTATION_STEPS]),
        "pipeline moved while stalled")

endmodule

/* bench/uv_check_pkg.sv */
// Expected-result predictor and scoreboard for the direction to equirect uv bench.
`timescale 1ns / 1ps

package uv_check_pkg;

    import d2eu_pkg::TEX_U_W;
    import d2eu_pkg::TEX_V_W;
    import d2eu_pkg::S_TDATA_W;
    import d2eu_pkg::ROTATION_STEPS_DEFAULT;

    localparam int     STEP_TABLE_LEN = 24;
    localparam longint COMP_SCALE     = 64'sd1048576;       // components scaled by 2^20
    localparam longint HALF_TURN_ANG  = 64'sd2147483648;    // 2^31 in 2^-32 turn units
    localparam longint unsigned INV_GAIN = 64'd10188014;    // 1/K in Q0.24
    localparam logic [TEX_V_W-1:0] V_EQUATOR = 17'd32768;
    localparam logic [TEX_V_W-1:0] V_TOP     = 17'd65536;

    // atan(2^-i) in 2^-32 turn units, truncated
    localparam longint STEP_ANGLE [STEP_TABLE_LEN] = '{
        64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4, 64'h028B_0D43,
        64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55, 64'h0028_BE53, 64'h0014_5F2F,
        64'h000A_2F98, 64'h0005_17CC, 64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2F9,
        64'h0000_517C, 64'h0000_28BE, 64'h0000_145F, 64'h0000_0A2F, 64'h0000_0517,
        64'h0000_028B, 64'h0000_0145, 64'h0000_00A2, 64'h0000_0051
    };

    typedef struct packed {
        logic               zero_vector;
        logic [TEX_V_W-1:0] tex_v;
        logic [TEX_U_W-1:0] tex_u;
    } texel_t;

    typedef struct {
        texel_t               want;
        logic [S_TDATA_W-1:0] dir;
    } pending_texel_t;

    // vectoring mode: rotate (x, y) onto the x axis, summing the turned angle
    function automatic void rotate_to_axis(inout longint x, inout longint y,
                                           inout longint ang);
        longint dx;
        longint dy;
        for (int i = 0; i < ROTATION_STEPS_DEFAULT && i < STEP_TABLE_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x   = x + dx;
                y   = y - dy;
                ang = ang + STEP_ANGLE[i];
            end else begin
                x   = x - dx;
                y   = y + dy;
                ang = ang - STEP_ANGLE[i];
            end
        end
    endfunction

    // u/v for one direction item as packed on s_tdata
    function automatic texel_t project_direction(input logic [S_TDATA_W-1:0] dir);
        longint x;
        longint y;
        longint z;
        longint ang;
        longint lat;
        longint r;
        longint vs;
        longint unsigned prod;
        logic [32:0] u_sum;
        texel_t t;
        x = longint'($signed(dir[15:0]));
        y = longint'($signed(dir[31:16]));
        z = longint'($signed(dir[47:32]));
        t = '0;
        if (x == 0 && y == 0 && z == 0) begin
            t.tex_v       = V_EQUATOR;
            t.zero_vector = 1'b1;
            return t;
        end
        x   = x * COMP_SCALE;
        y   = y * COMP_SCALE;
        z   = z * COMP_SCALE;
        ang = 0;
        lat = 0;
        r   = 0;
        // left half plane: turn by half a turn first
        if (x < 0) begin
            x   = -x;
            y   = -y;
            ang = HALF_TURN_ANG;
        end
        if (x != 0 || y != 0) begin
            rotate_to_axis(x, y, ang);
            u_sum   = {1'b0, ang[31:0]} + 33'h0_0000_8000;
            t.tex_u = u_sum[31:16];
            if (x < 0)
                x = 0;
            prod = x;
            prod = prod * INV_GAIN + (64'd1 << 23);
            r    = longint'(prod >> 24);
        end
        // latitude from (hypot, z)
        rotate_to_axis(r, z, lat);
        vs = (64'sd1 <<< 47) - lat + 64'sd16384;
        if (vs < 0)
            vs = 0;
        vs = vs >>> 15;
        if (vs > longint'(V_TOP))
            vs = longint'(V_TOP);
        t.tex_v = vs[TEX_V_W-1:0];
        return t;
    endfunction

    class uv_scoreboard;
        pending_texel_t texel_q[$];
        int unsigned    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return texel_q.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void note_direction(logic [S_TDATA_W-1:0] dir);
            pending_texel_t p;
            p.dir  = dir;
            p.want = project_direction(dir);
            texel_q.insert(texel_q.size(), p);
        endfunction

        task check_texel(logic [TEX_U_W-1:0] u, logic [TEX_V_W-1:0] v, logic zero_flag);
            pending_texel_t p;
            if (texel_q.size() == 0) begin
                report($sformatf("unexpected item u=%0d v=%0d zero=%0b", u, v, zero_flag));
                return;
            end
            p = texel_q.pop_front();
            if (u !== p.want.tex_u)
                report($sformatf("dir=%h tex_u got %0d want %0d", p.dir, u, p.want.tex_u));
            if (v !== p.want.tex_v)
                report($sformatf("dir=%h tex_v got %0d want %0d", p.dir, v, p.want.tex_v));
            if (zero_flag !== p.want.zero_vector)
                report($sformatf("dir=%h zero_vector got %0b want %0b", p.dir, zero_flag,
                                 p.want.zero_vector));
        endtask
    endclass

endpackage

/* bench/tb_direction_to_equirect_uv_core.sv */
// Testbench top for direction_to_equirect_uv_core: stimulus, flow control and checking.
`timescale 1ns / 1ps

module tb_direction_to_equirect_uv_core;

    import d2eu_pkg::*;
    import uv_check_pkg::*;

    localparam int LATENCY        = 2 * ROTATION_STEPS_DEFAULT + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 1728;
    localparam int TAIL_ITEMS     = 250;
    localparam int FILL_START     = 400;
    localparam int DRAIN_POINT    = 900;
    localparam int NUM_DIRECTED   = 21;

    localparam logic [15:0] CORNER_VALS [7] = '{
        16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF
    };

    // x, y, z per row: zero vector, poles, axes, half-turn line, corners
    localparam logic [15:0] DIRECTED [NUM_DIRECTED][3] = '{
        '{16'h0000, 16'h0000, 16'h0000},
        '{16'h0000, 16'h0000, 16'h0001},
        '{16'h0000, 16'h0000, 16'hFFFF},
        '{16'h0000, 16'h0000, 16'h7FFF},
        '{16'h0000, 16'h0000, 16'h8000},
        '{16'h0001, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'h0000, 16'h0000},
        '{16'h8000, 16'h0000, 16'h0000},
        '{16'h0000, 16'h0001, 16'h0000},
        '{16'h0000, 16'hFFFF, 16'h0000},
        '{16'h0000, 16'h7FFF, 16'h0000},
        '{16'h0000, 16'h8000, 16'h0000},
        '{16'h8000, 16'h8000, 16'h8000},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF},
        '{16'h8000, 16'h7FFF, 16'h0000},
        '{16'h7FFF, 16'h8000, 16'h8000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'h0001, 16'h0001, 16'h0001},
        '{16'h8000, 16'hFFFF, 16'h7FFF},
        '{16'h8000, 16'h0001, 16'h8000}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int idle_pct    = 0;
    int hold_left   = 0;
    int stall_left  = 0;
    int quiet_count = 0;

    uv_scoreboard sb = new();

    direction_to_equirect_uv_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // accepted items on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_direction(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_texel(m_tdata[15:0], m_tdata[32:16], m_tuser);
        end
    end

    // no progress on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL direction_to_equirect_uv_core");
                $finish;
            end
        end
    end

    // receiver: long hold on request, otherwise random stall bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_dir(input logic [S_TDATA_W-1:0] dir);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= dir;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // valid low for a gap of n, junk on the data lines
    task automatic idle_gap(input int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= S_TDATA_W'({$urandom, $urandom});
        repeat (n - 1)
            @(negedge aclk);
    endtask

    task automatic maybe_gap();
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            idle_gap($urandom_range(1, 14));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [S_TDATA_W-1:0] random_direction();
        logic [15:0]        comp [3];
        logic signed [15:0] wide;
        int                 sel;
        if ($urandom_range(0, 63) == 0)
            return '0;
        sel = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            wide = 16'($urandom);
            case (sel)
                0, 1, 2, 3: comp[k] = 16'($urandom);
                // tiny vectors, coarse angles
                4: comp[k] = 16'($urandom_range(0, 16)) - 16'd8;
                // axes and coordinate planes
                5: comp[k] = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'($urandom);
                6: comp[k] = CORNER_VALS[$urandom_range(0, 6)];
                // close to a pole
                7: comp[k] = (k == 2) ? 16'($urandom) :
                             (($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2)) - 16'd1
                                                          : 16'h0000);
                // left half plane close to the negative x axis
                8: comp[k] = (k == 0) ? (16'h8000 | 16'($urandom)) :
                             ((k == 1) ? 16'($urandom_range(0, 4)) - 16'd2 : 16'($urandom));
                default: comp[k] = wide >>> $urandom_range(0, 15);
            endcase
        end
        return {comp[2], comp[1], comp[0]};
    endfunction

    // stimulus and verdict
    initial begin
        repeat (7)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corner cases
        idle_pct = 20;
        for (int n = 0; n < NUM_DIRECTED; n++) begin
            send_dir({DIRECTED[n][2], DIRECTED[n][1], DIRECTED[n][0]});
            maybe_gap();
        end

        // random part with changing idle density
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 125 == 0) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 8;
                    2: idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end
            if (n >= RANDOM_ITEMS - TAIL_ITEMS)
                idle_pct = 0;
            // hold the output off while items keep coming until the pipe backs up
            if (n == FILL_START) begin
                idle_pct  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (n == DRAIN_POINT)
                drain_results();
            send_dir(random_direction());
            maybe_gap();
        end

        drain_results();
        repeat (LATENCY + 20)
            @(posedge aclk);
        if (sb.mismatches == 0)
            $display("PASS direction_to_equirect_uv_core");
        else
            $display("FAIL direction_to_equirect_uv_core");
        $finish;
    end

endmodule

/* direction_to_equirect_uv_core.f */
+incdir+rtl/core
rtl/core/d2eu_pkg.sv
rtl/core/d2eu_cordic_cell.sv
rtl/core/d2eu_out_buf.sv
rtl/core/direction_to_equirect_uv_core.sv
bench/uv_check_pkg.sv
bench/tb_direction_to_equirect_uv_core.sv
